/* src/quicksort_engine_core_macros.svh */
// ---------------------------------------------------------------------------
// quicksort_engine_core assertion macros
// Shorthands for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef QUICKSORT_ENGINE_CORE_MACROS_SVH
`define QUICKSORT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/qse_pkg.sv */
// ---------------------------------------------------------------------------
// qse_pkg
// Shared constants, state encoding and control structs of the sort engine.
// ---------------------------------------------------------------------------
package qse_pkg;

  localparam int unsigned QSE_MAX_ELEMENTS = 64;
  localparam int unsigned QSE_DATA_WIDTH   = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_SCAN_L,
    S_SCAN_R,
    S_SWAP,
    S_PUSH_HI,
    S_PUSH_LO,
    S_EMIT_RD,
    S_EMIT
  } qse_state_e;

  typedef struct packed {
    logic we;
    logic re;
  } qse_mem_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qse_stk_cmd_t;

  typedef struct packed {
    logic load;
    logic last_out;
    logic overflow;
  } qse_emit_t;

endpackage

/* src/qse_in_if.sv */
// ---------------------------------------------------------------------------
// qse_in_if
// Input channel: one element word with its end-of-set mark.
// ---------------------------------------------------------------------------
interface qse_in_if import qse_pkg::*; #(
  parameter int unsigned DATA_WIDTH = QSE_DATA_WIDTH
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);

endinterface

/* src/qse_out_if.sv */
// ---------------------------------------------------------------------------
// qse_out_if
// Output channel: one sorted word with end and overflow marks.
// ---------------------------------------------------------------------------
interface qse_out_if import qse_pkg::*; #(
  parameter int unsigned DATA_WIDTH = QSE_DATA_WIDTH
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sorted_value;
  logic                         last_out;
  logic                         overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);

endinterface

/* src/quicksort_engine_core.sv */
// ---------------------------------------------------------------------------
// quicksort_engine_core
// In-place Hoare-partition quicksort over a one-write one-read element RAM.
// ---------------------------------------------------------------------------
// Load: one word per cycle until the word marked last.
// Sort: each partition pops a range, reads the middle word as pivot, scans
//   inward from both ends and pushes the sub-ranges still to sort; each swap
//   takes a second write on the single write port of the element RAM.
// Emit: one word per cycle in order, while the output register is free.
// Reset clears the word count, overflow flag, stack pointer and output valid.
`include "quicksort_engine_core_macros.svh"

module quicksort_engine_core import qse_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = QSE_MAX_ELEMENTS,
  parameter int unsigned DATA_WIDTH   = QSE_DATA_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qse_in_if.sink    in_i,
  qse_out_if.source out_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);

  qse_mem_cmd_t                 mem_cmd;
  logic [IW-1:0]                mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]        mem_wdata, mem_rdata;
  qse_stk_cmd_t                 stk_cmd;
  logic [IW-1:0]                stk_push_left, stk_push_right;
  logic [IW-1:0]                stk_pop_left, stk_pop_right;
  logic                         stk_empty;
  qse_emit_t                    emit;
  logic                         out_free;

  logic                         out_valid_q, out_valid_d;
  logic signed [DATA_WIDTH-1:0] out_data_q;
  logic                         out_last_q, out_ovf_q;

  qse_store #(
    .DEPTH      (MAX_ELEMENTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  qse_stack #(
    .DEPTH (MAX_ELEMENTS)
  ) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (stk_cmd),
    .push_left_i  (stk_push_left),
    .push_right_i (stk_push_right),
    .pop_left_o   (stk_pop_left),
    .pop_right_o  (stk_pop_right),
    .empty_o      (stk_empty)
  );

  qse_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_value_i  (in_i.value),
    .in_last_i   (in_i.last_in),
    .in_ready_o  (in_i.ready),
    .mem_cmd_o   (mem_cmd),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i ($signed(mem_rdata)),
    .stk_cmd_o   (stk_cmd),
    .stk_left_o  (stk_push_left),
    .stk_right_o (stk_push_right),
    .stk_left_i  (stk_pop_left),
    .stk_right_i (stk_pop_right),
    .stk_empty_i (stk_empty),
    .out_free_i  (out_free),
    .emit_o      (emit)
  );

  // output register: refilled when empty or being drained this cycle
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_data_q <= $signed(mem_rdata);
      out_last_q <= emit.last_out;
      out_ovf_q  <= emit.overflow;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_data_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.overflow     = out_ovf_q;

  `QSE_ASSERT_IMP(a_load_into_free, emit.load, out_free, "output register overwritten")
  `QSE_ASSERT_IMP(a_emit_stack_empty, emit.load, stk_empty, "emitting with ranges pending")
  `QSE_ASSERT_IMP(a_load_stack_empty, in_i.valid && in_i.ready, stk_empty,
                  "accepting words with ranges pending")
  `QSE_ASSERT_NXT(a_hold_after_last, in_i.valid && in_i.ready && in_i.last_in, !in_i.ready,
                  "input not held off after last word")

endmodule

/* src/qse_store.sv */
// ---------------------------------------------------------------------------
// qse_store
// Element RAM: one write and one registered read per cycle, write-first.
// ---------------------------------------------------------------------------
module qse_store import qse_pkg::*; #(
  parameter int unsigned DEPTH      = QSE_MAX_ELEMENTS,
  parameter int unsigned DATA_WIDTH = QSE_DATA_WIDTH,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  qse_mem_cmd_t          cmd_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a read of the entry written in the same cycle returns the new word
  always_ff @(posedge clk_i) begin
    if (cmd_i.re) begin
      rdata_q <= (cmd_i.we && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/qse_stack.sv */
// ---------------------------------------------------------------------------
// qse_stack
// Range stack of pending (left, right) pairs held in a small RAM.
// ---------------------------------------------------------------------------
module qse_stack import qse_pkg::*; #(
  parameter int unsigned DEPTH = QSE_MAX_ELEMENTS,
  localparam int unsigned IW   = $clog2(DEPTH),
  localparam int unsigned PW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qse_stk_cmd_t  cmd_i,
  input  logic [IW-1:0] push_left_i,
  input  logic [IW-1:0] push_right_i,
  output logic [IW-1:0] pop_left_o,
  output logic [IW-1:0] pop_right_o,
  output logic          empty_o
);

  logic [2*IW-1:0] mem_q [DEPTH];
  logic [2*IW-1:0] rdata_q;
  logic [PW-1:0]   sp_q, sp_d;
  logic [PW-1:0]   sp_dec;
  logic            full;

  assign sp_dec  = sp_q - PW'(1);
  assign full    = (sp_q == PW'(DEPTH));
  assign empty_o = (sp_q == '0);

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push && !full) begin
      sp_d = sp_q + PW'(1);
    end else if (cmd_i.pop && !empty_o) begin
      sp_d = sp_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      mem_q[sp_q[IW-1:0]] <= {push_left_i, push_right_i};
    end
    if (cmd_i.pop && !empty_o) begin
      rdata_q <= mem_q[sp_dec[IW-1:0]];
    end
  end

  assign pop_left_o  = rdata_q[2*IW-1:IW];
  assign pop_right_o = rdata_q[IW-1:0];

endmodule

/* src/qse_ctrl.sv */
// ---------------------------------------------------------------------------
// qse_ctrl
// Sequencer: loads the store, runs the Hoare partition loop, streams out.
// ---------------------------------------------------------------------------
module qse_ctrl import qse_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = QSE_MAX_ELEMENTS,
  parameter int unsigned DATA_WIDTH   = QSE_DATA_WIDTH,
  localparam int unsigned IW          = $clog2(MAX_ELEMENTS),
  localparam int unsigned CW          = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input side
  input  logic                         in_valid_i,
  input  logic signed [DATA_WIDTH-1:0] in_value_i,
  input  logic                         in_last_i,
  output logic                         in_ready_o,
  // element store
  output qse_mem_cmd_t                 mem_cmd_o,
  output logic [IW-1:0]                mem_waddr_o,
  output logic [DATA_WIDTH-1:0]        mem_wdata_o,
  output logic [IW-1:0]                mem_raddr_o,
  input  logic signed [DATA_WIDTH-1:0] mem_rdata_i,
  // range stack
  output qse_stk_cmd_t                 stk_cmd_o,
  output logic [IW-1:0]                stk_left_o,
  output logic [IW-1:0]                stk_right_o,
  input  logic [IW-1:0]                stk_left_i,
  input  logic [IW-1:0]                stk_right_i,
  input  logic                         stk_empty_i,
  // output register
  input  logic                         out_free_i,
  output qse_emit_t                    emit_o
);

  // scan pointers run from -1 up to MAX_ELEMENTS
  localparam int unsigned PW = IW + 2;
  localparam logic signed [PW-1:0] PtrOne = PW'(1);

  qse_state_e state_q, state_d;

  logic [CW-1:0]                count_q, count_d;
  logic                         ovf_q, ovf_d;
  logic signed [PW-1:0]         pl_q, pl_d, pr_q, pr_d;
  logic [IW-1:0]                left_q, left_d, right_q, right_d;
  logic [IW-1:0]                k_q, k_d;
  logic signed [DATA_WIDTH-1:0] pivot_q, pivot_d, al_q, al_d;

  logic signed [PW-1:0] left_x, right_x, pl_inc, pr_dec;
  logic [IW:0]          mid_sum;
  logic [CW-1:0]        cnt_m1;
  logic [IW-1:0]        k_inc;
  logic                 k_last;

  assign left_x  = $signed({2'b00, left_q});
  assign right_x = $signed({2'b00, right_q});
  assign pl_inc  = pl_q + PtrOne;
  assign pr_dec  = pr_q - PtrOne;
  assign mid_sum = {1'b0, stk_left_i} + {1'b0, stk_right_i};
  assign cnt_m1  = count_q - CW'(1);
  assign k_inc   = k_q + IW'(1);
  assign k_last  = (CW'(k_q) == cnt_m1);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    pl_d    = pl_q;
    pr_d    = pr_q;
    left_d  = left_q;
    right_d = right_q;
    k_d     = k_q;
    pivot_d = pivot_q;
    al_d    = al_q;

    in_ready_o  = 1'b0;
    mem_cmd_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;
    stk_cmd_o   = '0;
    stk_left_o  = '0;
    stk_right_o = '0;
    emit_o      = '0;

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (count_q < CW'(MAX_ELEMENTS)) begin
            mem_cmd_o.we = 1'b1;
            mem_waddr_o  = count_q[IW-1:0];
            mem_wdata_o  = in_value_i;
            count_d      = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (count_q < CW'(2)) begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          stk_cmd_o.push = 1'b1;
          stk_left_o     = '0;
          stk_right_o    = cnt_m1[IW-1:0];
          state_d        = S_POP;
        end
      end
      S_POP: begin
        if (stk_empty_i) begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          stk_cmd_o.pop = 1'b1;
          state_d       = S_RANGE;
        end
      end
      S_RANGE: begin
        left_d       = stk_left_i;
        right_d      = stk_right_i;
        pl_d         = $signed({2'b00, stk_left_i});
        pr_d         = $signed({2'b00, stk_right_i});
        mem_cmd_o.re = 1'b1;
        mem_raddr_o  = mid_sum[IW:1];
        state_d      = S_PIVOT;
      end
      S_PIVOT: begin
        pivot_d      = mem_rdata_i;
        mem_cmd_o.re = 1'b1;
        mem_raddr_o  = pl_q[IW-1:0];
        state_d      = S_SCAN_L;
      end
      S_SCAN_L: begin
        mem_cmd_o.re = 1'b1;
        if ((pl_q < right_x) && (mem_rdata_i < pivot_q)) begin
          pl_d        = pl_inc;
          mem_raddr_o = pl_inc[IW-1:0];
        end else begin
          al_d        = mem_rdata_i;
          mem_raddr_o = pr_q[IW-1:0];
          state_d     = S_SCAN_R;
        end
      end
      S_SCAN_R: begin
        if ((pr_q > left_x) && (mem_rdata_i > pivot_q)) begin
          pr_d         = pr_dec;
          mem_cmd_o.re = 1'b1;
          mem_raddr_o  = pr_dec[IW-1:0];
        end else if (pl_q <= pr_q) begin
          // first half of the swap: right word goes to the left slot
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = pl_q[IW-1:0];
          mem_wdata_o  = mem_rdata_i;
          state_d      = S_SWAP;
        end else begin
          state_d = S_PUSH_HI;
        end
      end
      S_SWAP: begin
        mem_cmd_o.we = 1'b1;
        mem_waddr_o  = pr_q[IW-1:0];
        mem_wdata_o  = al_q;
        pl_d         = pl_inc;
        pr_d         = pr_dec;
        if (pl_inc <= pr_dec) begin
          mem_cmd_o.re = 1'b1;
          mem_raddr_o  = pl_inc[IW-1:0];
          state_d      = S_SCAN_L;
        end else begin
          state_d = S_PUSH_HI;
        end
      end
      S_PUSH_HI: begin
        if (right_x > pl_q) begin
          stk_cmd_o.push = 1'b1;
          stk_left_o     = pl_q[IW-1:0];
          stk_right_o    = right_q;
        end
        state_d = S_PUSH_LO;
      end
      S_PUSH_LO: begin
        if (left_x < pr_q) begin
          stk_cmd_o.push = 1'b1;
          stk_left_o     = left_q;
          stk_right_o    = pr_q[IW-1:0];
        end
        state_d = S_POP;
      end
      S_EMIT_RD: begin
        mem_cmd_o.re = 1'b1;
        mem_raddr_o  = k_q;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free_i) begin
          emit_o.load     = 1'b1;
          emit_o.last_out = k_last;
          emit_o.overflow = ovf_q;
          if (k_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d          = k_inc;
            mem_cmd_o.re = 1'b1;
            mem_raddr_o  = k_inc;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q    <= pl_d;
    pr_q    <= pr_d;
    left_q  <= left_d;
    right_q <= right_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    al_q    <= al_d;
  end

endmodule

/* tb/qse_sort_checker.sv */
// ---------------------------------------------------------------------------
// qse_sort_checker
// Watches both channels of the sort engine, keeps its own copy of the set
// being loaded, orders it when the last word arrives and compares every
// emitted word with the oldest word still expected.
// ---------------------------------------------------------------------------
module qse_sort_checker import qse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  qse_in_if    in_mon,
  qse_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = QSE_DATA_WIDTH;

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                last;
    logic                ovf;
  } sorted_word_t;

  sorted_word_t        sorted_q[$];
  logic signed [W-1:0] set_buf [QSE_MAX_ELEMENTS];
  int unsigned         set_cnt;
  logic                drop_seen;

  // Any correct sort yields the same sequence, so a plain insertion sort will do.
  function automatic void order_set(input int unsigned n);
    int unsigned         i;
    int unsigned         j;
    logic signed [W-1:0] key;
    for (i = 1; i < n; i++) begin
      key = set_buf[i];
      j = i;
      while (j > 0 && set_buf[j-1] > key) begin
        set_buf[j] = set_buf[j-1];
        j--;
      end
      set_buf[j] = key;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_word_t exp_w;
    int unsigned  k;
    if (!rst_ni) begin
      set_cnt   = 0;
      drop_seen = 1'b0;
      errors_o  = 0;
      sorted_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected word: value=%0d last=%0b ovf=%0b", $time,
                   out_mon.sorted_value, out_mon.last_out, out_mon.overflow);
        end else begin
          exp_w = sorted_q.pop_front();
          if (out_mon.sorted_value !== exp_w.value || out_mon.last_out !== exp_w.last ||
              out_mon.overflow !== exp_w.ovf) begin
            errors_o++;
            $display("%0t: mismatch (value/last/ovf): expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, exp_w.value, exp_w.last, exp_w.ovf,
                     out_mon.sorted_value, out_mon.last_out, out_mon.overflow);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        // words past capacity are dropped, but the set still ends on a last mark
        if (set_cnt < QSE_MAX_ELEMENTS) begin
          set_buf[set_cnt] = in_mon.value;
          set_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
        if (in_mon.last_in) begin
          order_set(set_cnt);
          for (k = 0; k < set_cnt; k++)
            sorted_q.push_back('{set_buf[k], k == set_cnt - 1, drop_seen});
          set_cnt   = 0;
          drop_seen = 1'b0;
        end
      end
    end
    pending_o = sorted_q.size();
  end

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Sort engine testbench: loads sets of signed words, directed corner sets
// first, then random sets of mixed sizes including full and overflowing ones,
// with bursty input and a stalling receiver. The checker does the scoring.
// ---------------------------------------------------------------------------
module tb import qse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W         = QSE_DATA_WIDTH;
  localparam int unsigned NUM_WORDS = 310;
  localparam int unsigned HOLD_LEN  = 400;

  localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

  // value patterns of a set
  typedef enum int {
    PAT_RANDOM,
    PAT_DUPS,
    PAT_EXTREME,
    PAT_RISING,
    PAT_FALLING
  } set_pat_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int errors;
  int pending;
  int words_sent;
  int burst_left;
  int rx_seg_left;
  int rx_mode;
  int hold_left;
  bit hold_req;
  bit hold_done;

  qse_in_if  in_ch ();
  qse_out_if out_ch ();

  quicksort_engine_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  qse_sort_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one word and returns at the edge where it is taken.
  task automatic put_word(input logic signed [W-1:0] v, input logic last);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.last_in <= last;
    burst_left--;
    words_sent++;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_set(input int unsigned n, input set_pat_e pat);
    int unsigned         i;
    logic signed [W-1:0] v;
    logic signed [W-1:0] base;
    base = $urandom_range(0, 2000) - 1000;
    for (i = 0; i < n; i++) begin
      case (pat)
        PAT_RANDOM:  v = $urandom;
        PAT_DUPS:    v = $signed($urandom_range(0, 7)) - 4;
        PAT_EXTREME: begin
          case ($urandom_range(0, 4))
            0:       v = VAL_MAX;
            1:       v = VAL_MIN;
            2:       v = '0;
            3:       v = '1;
            default: v = 1;
          endcase
        end
        PAT_RISING:  v = base + i;
        default:     v = base - i;
      endcase
      put_word(v, i == n - 1);
    end
  endtask

  function automatic set_pat_e set_set_pat();
    return set_pat_e'($urandom_range(0, 4));
  endfunction

  // receiver: segments of always ready, mostly ready and mostly stalled,
  // plus one long hold-off while a full set is emitted
  initial begin
    out_ch.ready = 1'b0;
    rx_seg_left  = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done && out_ch.valid) begin
        out_ch.ready <= 1'b0;
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end else begin
        if (rx_seg_left == 0) begin
          rx_seg_left = $urandom_range(5, 60);
          rx_mode     = $urandom_range(0, 2);
        end
        rx_seg_left--;
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned r;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last_in = 1'b0;
    words_sent    = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single word, the two extremes, mixed signs, duplicates, ordered runs
    put_word(VAL_MAX, 1'b1);
    put_word(VAL_MAX, 1'b0);
    put_word(VAL_MIN, 1'b1);
    put_word(0, 1'b0);
    put_word(VAL_MIN, 1'b0);
    put_word(-1, 1'b0);
    put_word(VAL_MAX, 1'b0);
    put_word(1, 1'b1);
    put_word(7, 1'b0);
    put_word(7, 1'b0);
    put_word(7, 1'b1);
    send_set(7, PAT_FALLING);
    send_set(5, PAT_RISING);

    // random: a full set under a long receiver hold-off, an overflowing set,
    // then mostly small sets with the odd full or overflowing one
    while (pending != 0) @(negedge clk_i);
    hold_req = 1'b1;
    send_set(QSE_MAX_ELEMENTS, PAT_RANDOM);
    send_set(QSE_MAX_ELEMENTS + $urandom_range(1, 6), set_set_pat());
    while (words_sent < NUM_WORDS) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        n = QSE_MAX_ELEMENTS;
      else if (r == 1)
        n = QSE_MAX_ELEMENTS + $urandom_range(1, 6);
      else
        n = $urandom_range(1, 12);
      send_set(n, set_set_pat());
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/qse_pkg.sv
src/qse_in_if.sv
src/qse_out_if.sv
src/qse_store.sv
src/qse_stack.sv
src/qse_ctrl.sv
src/quicksort_engine_core.sv
tb/qse_sort_checker.sv
tb/tb.sv
